@@ rtl/sac_pkg.sv @@
package sac_pkg;

    localparam int ADDR_W  = 64;
    localparam int STAMP_W = 64;
    localparam int SEED_W  = 32;

    localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
    localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1013904223;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'h9e3779b9;

    localparam logic [3:0] LINE_LOG2_MAX = 4'd12;

    // Remainder unit retires this many dividend bits per cycle.
    localparam int RMOD_STEPS = 4;

    typedef enum logic [1:0] {
        CFG_POLICY    = 2'd0,
        CFG_LINE_LOG2 = 2'd1,
        CFG_SET_LOG2  = 2'd2,
        CFG_WAYS      = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] POL_LRU    = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    localparam logic [1:0] RST_POLICY    = POL_LRU;
    localparam logic [3:0] RST_LINE_LOG2 = 4'd6;
    localparam logic [2:0] RST_SET_LOG2  = 3'd4;
    localparam logic [3:0] RST_WAYS      = 4'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]  tag;
        logic [STAMP_W-1:0] use_st;
        logic [STAMP_W-1:0] ins_st;
    } t_way;

endpackage

@@ rtl/sac_ram.sv @@
module sac_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sac_rmod.sv @@
module sac_rmod #(
    parameter int DIV_W = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sac_pkg::SEED_W-1:0] i_value,
    input  logic [DIV_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [DIV_W-1:0]          o_rem
);
    import sac_pkg::*;

    localparam int CYCLES = SEED_W / RMOD_STEPS;
    localparam int CNT_W  = $clog2(CYCLES + 1);

    logic [SEED_W-1:0] r_val, n_val;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;
    logic [DIV_W:0]    acc;

    // Restoring remainder, most significant bits first. The partial
    // remainder stays below the divisor, so one compare-subtract suffices.
    always_comb begin
        n_val = r_val;
        n_rem = r_rem;
        acc   = '0;
        for (int k = 0; k < RMOD_STEPS; k++) begin
            acc = {n_rem, n_val[SEED_W-1]};
            n_val = {n_val[SEED_W-2:0], 1'b0};
            if (acc >= {1'b0, r_div}) begin
                acc = acc - {1'b0, r_div};
            end
            n_rem = acc[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_val <= i_value;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_run) begin
                r_val <= n_val;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CYCLES - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/set_assoc_cache_replacement_top.sv @@
// A hit, or a miss into a set with a free way, reads its row in S_RD and shows its registered result from S_DEC.
// A miss into a full set adds a victim scan over the ways (LRU, FIFO) or an LCG
// remainder (random), then a write-back state; busy stays high until the result beat.
// One access at a time: a new access is taken only once busy is low; the row is read once.
// Reset: synchronous; afterwards a clearing pass zeroes one set per cycle until all MAX_SETS sets are clear.
// The result is a one-cycle strobe; the receiver cannot stall.
module set_assoc_cache_replacement_top #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sac_pkg::ADDR_W-1:0] i_address,
    output logic                       o_done,
    output logic                       o_hit,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [3:0]                 i_cfg_data
);
    import sac_pkg::*;

    localparam int SL_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int AW     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW     = $clog2(MAX_WAYS + 1);
    localparam int XW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef struct packed {
        logic [WW-1:0]              fill;
        t_way [MAX_WAYS-1:0]        ways;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_RD   = 7'b0000100,
        S_DEC  = 7'b0001000,
        S_SCAN = 7'b0010000,
        S_MOD  = 7'b0100000,
        S_WR   = 7'b1000000
    } t_state;

    t_state              r_state;
    logic [1:0]          r_policy;
    logic [3:0]          r_line_log2;
    logic [2:0]          r_set_log2;
    logic [3:0]          r_ways_cfg;
    logic [STAMP_W-1:0]  r_cnt;
    logic [SEED_W-1:0]   r_seed;
    logic [AW-1:0]       r_clr;
    logic [AW-1:0]       r_set;
    logic [ADDR_W-1:0]   r_tag;
    t_row                r_row;
    logic [WW-1:0]       r_valid;
    logic                r_hit;
    logic [XW-1:0]       r_hway;
    logic [XW-1:0]       r_vic;
    logic [XW-1:0]       r_idx;
    logic                r_done;
    logic                r_out_hit;

    logic [3:0]          lb_eff;
    logic [2:0]          sl_eff;
    logic [WW-1:0]       ways_eff;
    logic [ADDR_W-1:0]   line;
    logic [AW-1:0]       set_calc;
    logic [ADDR_W-1:0]   tag_calc;
    t_row                rd_row;
    logic [ROW_W-1:0]    ram_rdata;
    logic [WW-1:0]       rd_valid;
    logic                rd_hit;
    logic [XW-1:0]       rd_hway;
    logic [STAMP_W-1:0]  cnt_inc;
    logic [SEED_W-1:0]   seed_next;
    logic                is_lru;
    logic                do_refresh;
    logic                do_fill;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_row                wrow;
    logic [STAMP_W-1:0]  st_idx;
    logic [STAMP_W-1:0]  st_vic;
    logic                rmod_start;
    logic                rmod_done;
    logic [WW-1:0]       rmod_rem;

    assign lb_eff = (r_line_log2 > LINE_LOG2_MAX) ? LINE_LOG2_MAX : r_line_log2;
    assign sl_eff = (32'(r_set_log2) > SL_MAX) ? 3'(SL_MAX) : r_set_log2;

    always_comb begin
        if (r_ways_cfg == 4'd0) begin
            ways_eff = WW'(1);
        end else if (32'(r_ways_cfg) > MAX_WAYS) begin
            ways_eff = WW'(MAX_WAYS);
        end else begin
            ways_eff = WW'(r_ways_cfg);
        end
    end

    assign line     = i_address >> lb_eff;
    assign set_calc = AW'(line & ((64'd1 << sl_eff) - 64'd1));
    assign tag_calc = line >> sl_eff;

    assign rd_row   = t_row'(ram_rdata);
    assign rd_valid = (rd_row.fill < ways_eff) ? rd_row.fill : ways_eff;

    always_comb begin
        rd_hit  = 1'b0;
        rd_hway = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (32'(rd_valid) > i && rd_row.ways[i].tag == r_tag) begin
                rd_hit  = 1'b1;
                rd_hway = XW'(i);
            end
        end
    end

    assign cnt_inc    = r_cnt + 64'd1;
    assign seed_next  = SEED_W'(r_seed * LCG_MUL + LCG_ADD);
    assign is_lru     = (r_policy == POL_LRU);
    assign do_refresh = r_hit && is_lru;
    assign do_fill    = !r_hit && (r_valid < ways_eff);
    assign rmod_start = (r_state == S_DEC) && !r_hit && !do_fill
                        && (r_policy == POL_RANDOM);

    assign st_idx = is_lru ? r_row.ways[r_idx].use_st : r_row.ways[r_idx].ins_st;
    assign st_vic = is_lru ? r_row.ways[r_vic].use_st : r_row.ways[r_vic].ins_st;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_set;
        wrow      = r_row;
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                wrow      = '0;
            end
            S_DEC: begin
                if (do_refresh) begin
                    ram_we = 1'b1;
                    wrow.ways[r_hway].use_st = cnt_inc;
                end else if (do_fill) begin
                    ram_we = 1'b1;
                    wrow.fill = WW'(r_valid + 1'b1);
                    wrow.ways[XW'(r_valid)].tag    = r_tag;
                    wrow.ways[XW'(r_valid)].use_st = cnt_inc;
                    wrow.ways[XW'(r_valid)].ins_st = cnt_inc;
                end
            end
            S_WR: begin
                ram_we = 1'b1;
                wrow.ways[r_vic].tag    = r_tag;
                wrow.ways[r_vic].use_st = r_cnt;
                wrow.ways[r_vic].ins_st = r_cnt;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS),
        .ADDR_W(AW)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ROW_W'(wrow)),
        .i_raddr(set_calc),
        .o_rdata(ram_rdata)
    );

    sac_rmod #(
        .DIV_W(WW)
    ) u_rmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rmod_start),
        .i_value  (seed_next),
        .i_divisor(ways_eff),
        .o_done   (rmod_done),
        .o_rem    (rmod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_policy    <= RST_POLICY;
            r_line_log2 <= RST_LINE_LOG2;
            r_set_log2  <= RST_SET_LOG2;
            r_ways_cfg  <= RST_WAYS;
            r_cnt       <= '0;
            r_seed      <= SEED_RESET;
            r_done      <= 1'b0;
            r_out_hit   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_POLICY:    r_policy    <= i_cfg_data[1:0];
                    CFG_LINE_LOG2: r_line_log2 <= i_cfg_data;
                    CFG_SET_LOG2:  r_set_log2  <= i_cfg_data[2:0];
                    CFG_WAYS:      r_ways_cfg  <= i_cfg_data;
                    default:       r_policy    <= r_policy;
                endcase
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAX_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_set   <= set_calc;
                        r_tag   <= tag_calc;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_row   <= rd_row;
                    r_valid <= rd_valid;
                    r_hit   <= rd_hit;
                    r_hway  <= rd_hway;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_hit) begin
                        if (is_lru) begin
                            r_cnt <= cnt_inc;
                        end
                        r_done    <= 1'b1;
                        r_out_hit <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_cnt <= cnt_inc;
                        r_vic <= '0;
                        r_idx <= XW'(1);
                        if (do_fill) begin
                            r_done    <= 1'b1;
                            r_out_hit <= 1'b0;
                            r_state   <= S_IDLE;
                        end else if (r_policy == POL_RANDOM) begin
                            r_seed  <= seed_next;
                            r_state <= S_MOD;
                        end else if (ways_eff == WW'(1)) begin
                            r_state <= S_WR;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Strict compare keeps the lowest way among equal stamps.
                    if (st_idx < st_vic) begin
                        r_vic <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (32'(r_idx) == 32'(ways_eff) - 1) begin
                        r_state <= S_WR;
                    end
                end
                S_MOD: begin
                    if (rmod_done) begin
                        r_vic   <= XW'(rmod_rem);
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_done    <= 1'b1;
                    r_out_hit <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_hit       = r_out_hit;
    // Registers change only between accesses, never beside a new start.
    assign o_cfg_ready = !busy && !start;

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_DEC || $past(r_state) == S_WR))
        else $error("result beat without a decide or write-back cycle");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !(r_state == S_IDLE || r_state == S_RD))
        else $error("row write while idle or reading");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_RD))
        else $error("accepted access did not start a row read");

    a_victim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (32'(r_vic) < 32'(ways_eff)))
        else $error("victim way outside the ways in use");

endmodule

@@ bench/testbench.sv @@
module testbench;
    import sac_pkg::*;

    // Predicts hit or miss for each accepted access and holds the expected answers.
    class hit_scoreboard;
        logic [1:0]  policy = RST_POLICY;
        logic [3:0]  line_log2 = RST_LINE_LOG2;
        logic [2:0]  set_log2 = RST_SET_LOG2;
        logic [3:0]  ways_cfg = RST_WAYS;
        int unsigned fill[64];
        logic [63:0] tags[64][8];
        logic [63:0] used[64][8];
        logic [63:0] inserted[64][8];
        logic [63:0] access_cnt = '0;
        logic [31:0] lcg_seed = SEED_RESET;
        bit          exp_ring[2048];
        int unsigned wr_cnt = 0;
        int unsigned rd_cnt = 0;
        int          errors = 0;
        int          hits = 0;
        int          misses = 0;
        int          evictions = 0;

        function void write_reg(logic [1:0] idx, logic [3:0] data);
            case (idx)
                CFG_POLICY:    policy = data[1:0];
                CFG_LINE_LOG2: line_log2 = data;
                CFG_SET_LOG2:  set_log2 = data[2:0];
                CFG_WAYS:      ways_cfg = data;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return wr_cnt - rd_cnt;
        endfunction

        function void queue_result(bit h);
            exp_ring[wr_cnt % 2048] = h;
            wr_cnt++;
        endfunction

        function int unsigned eff_line();
            return (line_log2 > 12) ? 12 : line_log2;
        endfunction

        function int unsigned eff_sets();
            return (set_log2 > 6) ? 6 : set_log2;
        endfunction

        function int unsigned eff_ways();
            if (ways_cfg == 0) return 1;
            if (ways_cfg > 8) return 8;
            return ways_cfg;
        endfunction

        function void note_access(logic [63:0] addr);
            logic [63:0] line_no;
            logic [63:0] tag;
            logic [63:0] prod;
            int unsigned set_no;
            int unsigned nways;
            int unsigned valid;
            int unsigned victim;
            bit          found;
            line_no = addr >> eff_line();
            set_no  = 32'(line_no & ((64'd1 << eff_sets()) - 64'd1));
            tag     = line_no >> eff_sets();
            nways   = eff_ways();
            valid   = (fill[set_no] < nways) ? fill[set_no] : nways;
            found   = 0;
            for (int i = 0; i < valid && !found; i++) begin
                if (tags[set_no][i] == tag) begin
                    found = 1;
                    if (policy == POL_LRU) begin
                        access_cnt++;
                        used[set_no][i] = access_cnt;
                    end
                end
            end
            if (found) begin
                hits++;
                queue_result(1'b1);
                return;
            end
            access_cnt++;
            victim = 0;
            if (valid < nways) begin
                victim = valid;
                fill[set_no] = valid + 1;
            end else begin
                evictions++;
                if (policy == POL_RANDOM) begin
                    prod = lcg_seed * LCG_MUL + LCG_ADD;
                    lcg_seed = prod[31:0];
                    victim = lcg_seed % nways;
                end else if (policy == POL_LRU) begin
                    for (int i = 1; i < nways; i++)
                        if (used[set_no][i] < used[set_no][victim]) victim = i;
                end else begin
                    // Policy code three falls here and behaves as FIFO.
                    for (int i = 1; i < nways; i++)
                        if (inserted[set_no][i] < inserted[set_no][victim]) victim = i;
                end
            end
            tags[set_no][victim] = tag;
            used[set_no][victim] = access_cnt;
            inserted[set_no][victim] = access_cnt;
            misses++;
            queue_result(1'b0);
        endfunction

        function void check_hit(logic actual);
            bit exp_hit;
            if (pending() == 0) begin
                $error("hit: result beat with no access outstanding, actual %0d", actual);
                errors++;
                return;
            end
            exp_hit = exp_ring[rd_cnt % 2048];
            rd_cnt++;
            if (actual !== exp_hit) begin
                $error("hit: expected %0d actual %0d", exp_hit, actual);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [63:0] i_address = '0;
    logic        o_done;
    logic        o_hit;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;

    hit_scoreboard sb = new();
    int accepted = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;
    int idle_pct = 0;

    set_assoc_cache_replacement_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_address(i_address), .o_done(o_done), .o_hit(o_hit),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_done) begin
                sb.check_hit(o_hit);
                quiet_cycles = 0;
            end
            if (start && !busy) begin
                sb.note_access(i_address);
                accepted++;
                quiet_cycles = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                cfg_writes++;
                quiet_cycles = 0;
            end
            if (quiet_cycles >= 5000) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Holds start high until the beat is taken; afterwards each cycle is idle with
    // probability idle_pct percent.
    task automatic send_access(logic [63:0] addr);
        int n;
        n = accepted;
        start = 1;
        i_address = addr;
        @(negedge i_clk);
        while (accepted == n) @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 0;
            i_address = {$urandom, $urandom};
            @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        // Every result is back, so the block is idle; leave a quiet gap between phases.
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [3:0] data);
        int n;
        n = cfg_writes;
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        while (cfg_writes == n) @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic set_config(logic [3:0] pol, logic [3:0] ln, logic [3:0] st, logic [3:0] wy);
        drain();
        write_cfg(CFG_POLICY, pol);
        write_cfg(CFG_LINE_LOG2, ln);
        write_cfg(CFG_SET_LOG2, st);
        write_cfg(CFG_WAYS, wy);
    endtask

    // Mostly small tags so sets fill, hit and evict; some fully random addresses.
    function automatic logic [63:0] pick_address();
        int unsigned lb;
        int unsigned sl;
        logic [63:0] tag;
        logic [63:0] set_no;
        logic [63:0] offs;
        lb = sb.eff_line();
        sl = sb.eff_sets();
        if ($urandom_range(0, 99) < 10) return {$urandom, $urandom};
        tag = 64'($urandom_range(0, 2 * sb.eff_ways() + 1));
        set_no = 64'($urandom_range(0, (1 << sl) - 1));
        offs = {$urandom, $urandom} & ((64'd1 << lb) - 1);
        return (tag << (lb + sl)) | (set_no << lb) | offs;
    endfunction

    logic [3:0] phase_cfg[9][4] = '{
        '{4'd1, 4'd0,  4'd0, 4'd1},
        '{4'd2, 4'd12, 4'd6, 4'd8},
        '{4'd3, 4'd15, 4'd7, 4'd0},
        '{4'd0, 4'd3,  4'd1, 4'd2},
        '{4'd2, 4'd4,  4'd2, 4'd15},
        '{4'd1, 4'd5,  4'd3, 4'd3},
        '{4'd0, 4'd2,  4'd0, 4'd8},
        '{4'd0, 4'd2,  4'd0, 4'd2},
        '{4'd2, 4'd1,  4'd1, 4'd5}
    };

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extremes of the address under the reset configuration.
        send_access('0);
        send_access('1);
        send_access('0);
        send_access('1);
        send_access(64'h5555_5555_5555_5555);
        send_access(64'haaaa_aaaa_aaaa_aaaa);
        // Six tags into one set with four ways force LRU evictions.
        for (int t = 0; t < 6; t++) send_access(64'(t) << 10);
        send_access(64'd0);
        send_access(64'd1 << 10);

        for (int p = 0; p < 9; p++) begin
            set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 74;
                default: idle_pct = 6;
            endcase
            for (int k = 0; k < 160; k++) begin
                if (p == 4 && k == 80) drain();
                send_access(pick_address());
            end
        end

        drain();
        $display("covered %0d accesses (%0d hits, %0d misses, %0d evictions)",
                 accepted, sb.hits, sb.misses, sb.evictions);
        $display("over %0d register writes across all policies and size extremes", cfg_writes);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

@@ set_assoc_cache_replacement_top.f @@
rtl/sac_pkg.sv
rtl/sac_ram.sv
rtl/sac_rmod.sv
rtl/set_assoc_cache_replacement_top.sv
bench/testbench.sv
